FILE: design/tekd_pkg.sv
// Shared types, constants and helper functions of the terminal escape key decoder.
package tekd_pkg;

  localparam int BUF_BYTES = 16;
  localparam int IDX_W = $clog2(BUF_BYTES);
  localparam int ACC_W = 16;

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0]       key_t;
  typedef logic [ACC_W-1:0] acc_t;

  localparam idx_t CNT_MAX = IDX_W'(BUF_BYTES - 1);
  localparam logic [IDX_W:0] PTR_WRAP = (IDX_W + 1)'(BUF_BYTES);

  localparam acc_t SAT_LIMIT = 16'h8000;
  localparam acc_t COORD_MAX = 16'h7fff;

  localparam byte_t CH_ESC    = 8'd27;
  localparam byte_t CH_O      = 8'h4f;
  localparam byte_t CH_LBRACK = 8'h5b;
  localparam byte_t CH_TILDE  = 8'h7e;
  localparam byte_t CH_SEMI   = 8'h3b;
  localparam byte_t CH_R      = 8'h52;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_A      = 8'h41;
  localparam byte_t CH_B      = 8'h42;
  localparam byte_t CH_C      = 8'h43;
  localparam byte_t CH_D      = 8'h44;
  localparam byte_t CH_F      = 8'h46;
  localparam byte_t CH_H      = 8'h48;
  localparam byte_t CH_1      = 8'h31;
  localparam byte_t CH_2      = 8'h32;
  localparam byte_t CH_3      = 8'h33;
  localparam byte_t CH_4      = 8'h34;
  localparam byte_t CH_5      = 8'h35;
  localparam byte_t CH_6      = 8'h36;
  localparam byte_t CH_7      = 8'h37;
  localparam byte_t CH_8      = 8'h38;

  localparam key_t KEY_UP     = 4'd0;
  localparam key_t KEY_DOWN   = 4'd1;
  localparam key_t KEY_RIGHT  = 4'd2;
  localparam key_t KEY_LEFT   = 4'd3;
  localparam key_t KEY_HOME   = 4'd4;
  localparam key_t KEY_END    = 4'd5;
  localparam key_t KEY_INSERT = 4'd6;
  localparam key_t KEY_DELETE = 4'd7;
  localparam key_t KEY_PGUP   = 4'd8;
  localparam key_t KEY_PGDN   = 4'd9;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_END  = 2'd2,
    ACT_RSVD = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEQ    = 2'd1,
    PH_REPORT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SUB_ROW_FIRST = 2'd0,
    SUB_ROW       = 2'd1,
    SUB_COL_FIRST = 2'd2,
    SUB_COL       = 2'd3
  } sub_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_START = 4'd1,
    ST_DTOP  = 4'd2,
    ST_DUSE  = 4'd3,
    ST_CRD   = 4'd4,
    ST_CUSE  = 4'd5,
    ST_PRD   = 4'd6,
    ST_PUSE  = 4'd7,
    ST_FIN   = 4'd8
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_value;
    logic [3:0]  key_code;
    logic [14:0] row;
    logic [14:0] col;
    logic        last;
  } out_t;

  function automatic idx_t ptr_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PTR_WRAP) begin
      s = s - PTR_WRAP;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic is_digit(byte_t b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_arrow(byte_t b);
    return (b == CH_A) || (b == CH_B) || (b == CH_C) || (b == CH_D) ||
           (b == CH_H) || (b == CH_F);
  endfunction

  function automatic key_t arrow_key(byte_t b);
    key_t k;
    case (b)
      CH_A: k = KEY_UP;
      CH_B: k = KEY_DOWN;
      CH_C: k = KEY_RIGHT;
      CH_D: k = KEY_LEFT;
      CH_H: k = KEY_HOME;
      CH_F: k = KEY_END;
      default: k = KEY_UP;
    endcase
    return k;
  endfunction

  function automatic logic is_tilde_digit(byte_t b);
    return (b >= CH_1) && (b <= CH_8);
  endfunction

  function automatic key_t tilde_key(byte_t b);
    key_t k;
    case (b)
      CH_1: k = KEY_HOME;
      CH_2: k = KEY_INSERT;
      CH_3: k = KEY_DELETE;
      CH_4: k = KEY_END;
      CH_5: k = KEY_PGUP;
      CH_6: k = KEY_PGDN;
      CH_7: k = KEY_HOME;
      CH_8: k = KEY_END;
      default: k = KEY_HOME;
    endcase
    return k;
  endfunction

endpackage

FILE: design/terminal_escape_key_decoder.sv
// Terminal escape key decoder: byte buffer, recognizer sequencer and result staging.
//
//   channel | ports                          | direction | transaction on
//   input   | in_valid, in_stall, in_data    | in        | in_valid & !in_stall
//   result  | out_valid, out_stall, out_data | out       | out_valid & !out_stall
//   config  | cfg_wr_en, cfg_wr_data         | in        | cfg_wr_en
//
// The input stalls from the accepting edge until the sequencer is idle again: it decodes
// the action, reads each held byte the recognizer uses, takes a step for each check that
// reads nothing (empty buffer, lookup entry, incomplete lookup, open report, escape emitted
// without a read), and then closes the transaction.
// A new result waits while one is staged and the output register is stalled. Reset is
// synchronous, needs no clearing pass, and sets report decoding on.
module terminal_escape_key_decoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tekd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tekd_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data
);
  import tekd_pkg::*;

  byte_t  mem [BUF_BYTES];

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  idx_t   head_r, head_nxt;
  idx_t   count_r, count_nxt;
  logic   enable_r;
  act_t   act_r, act_nxt;
  byte_t  byte_r, byte_nxt;
  idx_t   idx_r, idx_nxt;
  sub_t   sub_r, sub_nxt;
  acc_t   row_acc_r, row_nxt;
  acc_t   col_acc_r, col_nxt;
  byte_t  b0_r, b0_nxt;
  byte_t  b1_r, b1_nxt;
  byte_t  rd_data_r;
  out_t   pend_r, pend_nxt;
  logic   pend_v_r, pend_v_nxt;
  out_t   out_data_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic   in_accept;
  logic   out_free;
  logic   emit_ok;
  logic   emit_go;
  out_t   emit_res;
  logic   fin_go;
  logic   rd_en;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  byte_t  wr_data;
  acc_t   acc_sel;
  logic [ACC_W+3:0] mac;
  acc_t   acc_sat;
  logic   rd_is_digit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_ok   = !pend_v_r || out_free;

  // Shared digit accumulate unit: acc * 10 + digit, saturated
  assign acc_sel     = (sub_r == SUB_COL) ? col_acc_r : row_acc_r;
  assign mac         = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} +
                       {{ACC_W{1'b0}}, rd_data_r[3:0]};
  assign acc_sat     = (mac > {4'b0000, SAT_LIMIT}) ? SAT_LIMIT : mac[ACC_W-1:0];
  assign rd_is_digit = is_digit(rd_data_r);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    act_nxt   = act_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    row_nxt   = row_acc_r;
    col_nxt   = col_acc_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_add(head_r, idx_r);
    wr_en     = 1'b0;
    wr_addr   = ptr_add(head_r, count_r);
    wr_data   = in_data.rx_byte;
    emit_go   = 1'b0;
    emit_res  = '0;
    fin_go    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          act_nxt  = act_t'(in_data.action);
          byte_nxt = in_data.rx_byte;
          if ((act_t'(in_data.action) == ACT_BYTE) && (count_r != CNT_MAX)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + IDX_W'(1);
          end
          state_nxt = ST_START;
        end
      end

      ST_START: begin
        case (act_r)
          ACT_BYTE: begin
            if (phase_r == PH_REPORT && byte_r == CH_R) begin
              idx_nxt   = IDX_W'(1);
              sub_nxt   = SUB_ROW_FIRST;
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = ST_PRD;
            end else if (phase_r == PH_REPORT && count_r == CNT_MAX) begin
              if (emit_ok) begin
                emit_go             = 1'b1;
                emit_res.kind       = KIND_CHAR;
                emit_res.char_value = CH_ESC;
                phase_nxt           = PH_IDLE;
                state_nxt           = ST_DTOP;
              end
            end else begin
              state_nxt = ST_DTOP;
            end
          end
          ACT_TICK: begin
            if (phase_r == PH_IDLE) begin
              state_nxt = ST_FIN;
            end else if (emit_ok) begin
              emit_go             = 1'b1;
              emit_res.kind       = KIND_CHAR;
              emit_res.char_value = CH_ESC;
              phase_nxt           = PH_IDLE;
              state_nxt           = ST_DTOP;
            end
          end
          ACT_END: begin
            if (emit_ok) begin
              emit_go       = 1'b1;
              emit_res.kind = KIND_ERROR;
              phase_nxt     = PH_IDLE;
              state_nxt     = ST_DTOP;
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_DTOP: begin
        case (phase_r)
          PH_IDLE: begin
            if (count_r == '0) begin
              state_nxt = ST_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = ST_DUSE;
            end
          end
          PH_SEQ: begin
            idx_nxt   = '0;
            state_nxt = ST_CRD;
          end
          PH_REPORT: begin
            if (count_r != CNT_MAX) begin
              state_nxt = ST_FIN;
            end else if (emit_ok) begin
              emit_go             = 1'b1;
              emit_res.kind       = KIND_CHAR;
              emit_res.char_value = CH_ESC;
              phase_nxt           = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end

      ST_DUSE: begin
        if (rd_data_r == CH_ESC) begin
          head_nxt  = ptr_add(head_r, IDX_W'(1));
          count_nxt = count_r - IDX_W'(1);
          phase_nxt = PH_SEQ;
          state_nxt = ST_DTOP;
        end else if (emit_ok) begin
          emit_go             = 1'b1;
          emit_res.kind       = KIND_CHAR;
          emit_res.char_value = rd_data_r;
          head_nxt            = ptr_add(head_r, IDX_W'(1));
          count_nxt           = count_r - IDX_W'(1);
          state_nxt           = ST_DTOP;
        end
      end

      ST_CRD: begin
        if (idx_r >= count_r) begin
          state_nxt = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CUSE;
        end
      end

      ST_CUSE: begin
        if (idx_r == '0 && (rd_data_r == CH_O || rd_data_r == CH_LBRACK)) begin
          b0_nxt    = rd_data_r;
          idx_nxt   = IDX_W'(1);
          state_nxt = ST_CRD;
        end else if (idx_r == IDX_W'(1) && b0_r == CH_LBRACK &&
                     is_tilde_digit(rd_data_r)) begin
          b1_nxt    = rd_data_r;
          idx_nxt   = IDX_W'(2);
          state_nxt = ST_CRD;
        end else if ((idx_r == IDX_W'(1) && is_arrow(rd_data_r)) ||
                     (idx_r == IDX_W'(2) && rd_data_r == CH_TILDE)) begin
          if (emit_ok) begin
            emit_go       = 1'b1;
            emit_res.kind = KIND_KEY;
            emit_res.key_code = (idx_r == IDX_W'(1)) ? arrow_key(rd_data_r)
                                                     : tilde_key(b1_r);
            head_nxt  = ptr_add(head_r, idx_r + IDX_W'(1));
            count_nxt = count_r - (idx_r + IDX_W'(1));
            phase_nxt = PH_IDLE;
            state_nxt = ST_DTOP;
          end
        end else if (enable_r && idx_r != '0 && b0_r == CH_LBRACK) begin
          phase_nxt = PH_REPORT;
          state_nxt = ST_DTOP;
        end else if (emit_ok) begin
          emit_go             = 1'b1;
          emit_res.kind       = KIND_CHAR;
          emit_res.char_value = CH_ESC;
          phase_nxt           = PH_IDLE;
          state_nxt           = ST_DTOP;
        end
      end

      ST_PRD: begin
        if (idx_r >= count_r) begin
          if (emit_ok) begin
            emit_go             = 1'b1;
            emit_res.kind       = KIND_CHAR;
            emit_res.char_value = CH_ESC;
            phase_nxt           = PH_IDLE;
            state_nxt           = ST_DTOP;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_PUSE;
        end
      end

      ST_PUSE: begin
        if (rd_is_digit && (sub_r == SUB_ROW_FIRST || sub_r == SUB_ROW)) begin
          row_nxt   = (sub_r == SUB_ROW) ? acc_sat : {12'h000, rd_data_r[3:0]};
          sub_nxt   = SUB_ROW;
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_PRD;
        end else if (rd_is_digit && (sub_r == SUB_COL_FIRST || sub_r == SUB_COL)) begin
          col_nxt   = (sub_r == SUB_COL) ? acc_sat : {12'h000, rd_data_r[3:0]};
          sub_nxt   = SUB_COL;
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_PRD;
        end else if (sub_r == SUB_ROW && rd_data_r == CH_SEMI) begin
          sub_nxt   = SUB_COL_FIRST;
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_PRD;
        end else if (sub_r == SUB_COL && rd_data_r == CH_R &&
                     row_acc_r != '0 && row_acc_r <= COORD_MAX &&
                     col_acc_r != '0 && col_acc_r <= COORD_MAX) begin
          if (emit_ok) begin
            emit_go       = 1'b1;
            emit_res.kind = KIND_CURSOR;
            emit_res.row  = row_acc_r[14:0];
            emit_res.col  = col_acc_r[14:0];
            head_nxt      = ptr_add(head_r, idx_r + IDX_W'(1));
            count_nxt     = count_r - (idx_r + IDX_W'(1));
            phase_nxt     = PH_IDLE;
            state_nxt     = ST_DTOP;
          end
        end else if (emit_ok) begin
          emit_go             = 1'b1;
          emit_res.kind       = KIND_CHAR;
          emit_res.char_value = CH_ESC;
          phase_nxt           = PH_IDLE;
          state_nxt           = ST_DTOP;
        end
      end

      ST_FIN: begin
        if (!pend_v_r || out_free) begin
          fin_go    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Stage each result one behind so the final one can carry last
  always_comb begin
    out_nxt       = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    if (emit_go) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_nxt.last  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end
    if (fin_go && pend_v_r) begin
      out_nxt       = pend_r;
      out_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    sub_r      <= sub_nxt;
    row_acc_r  <= row_nxt;
    col_acc_r  <= col_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r == PH_IDLE) |-> (count_r == '0))
    else $error("bytes left over with recognizer idle");

  a_seq_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r == PH_SEQ) |-> (count_r <= IDX_W'(2)))
    else $error("escape lookup waiting with more than two bytes held");

  a_report_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && phase_r == PH_REPORT) |-> (count_r != CNT_MAX))
    else $error("report collection waiting on a full buffer");

  a_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("result still staged after transaction closed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_CURSOR) |->
      (out_data_r.row != '0 && out_data_r.col != '0))
    else $error("cursor result with zero coordinate");

endmodule
